/* sv/mmhq_pkg.sv */
`default_nettype none
package mmhq_pkg;

    localparam int CAPACITY_DEF = 1024;

    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_POP_MIN = 2'd1;
    localparam logic [1:0] FUNC_POP_MAX = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_CMP_PAR,
        ST_BUB_RD,
        ST_BUB_CMP,
        ST_REM_LAST,
        ST_TD_CHECK,
        ST_TD_RD,
        ST_TD_SWAP,
        ST_TD_CMP_PAR,
        ST_PLACE,
        ST_PK_RD1,
        ST_PK_RD2,
        ST_PK_RD3,
        ST_PK_DONE
    } mmhq_state_t;

    function automatic logic better(input logic signed [31:0] a,
                                    input logic signed [31:0] b,
                                    input logic want_max);
        return want_max ? (a > b) : (a < b);
    endfunction

endpackage
`default_nettype wire

/* sv/mmhq_ram.sv */
`default_nettype none
module mmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* sv/min_max_heap_queue.sv */
`default_nettype none
// Double-ended priority queue of signed 32-bit keys held as a min-max heap.
// The input channel (s_valid/s_ready) takes one word per operation: s_func
// selects insert of s_key_in, removal of the minimum or removal of the maximum.
// The result channel (m_valid/m_ready) returns one word per operation with the
// status, the removed key, the current minimum and maximum and the key count.
// Keys live in a RAM with a registered read; the steps run under a sequencer,
// and s_ready is high only when the sequencer is idle and no result is waiting.
// A rejected or unused word goes straight to the final reads; the first key is
// placed at once, and any other insert compares with its parent and then climbs
// one grandparent level per step.
// A removal moves the last key to the vacated position and walks it down level
// pairs; each step makes up to six descendant reads through the one read port,
// and a last step to a child ends the walk.
// Every operation ends with reads of positions 1 to 3 for min and max.
// The next word is taken in the cycle after the result is accepted.
// Reset empties the queue at once; no clearing of the RAM is needed.
// When the receiver stalls, the result is held and no new word is taken.
module min_max_heap_queue #(
    parameter int CAPACITY = mmhq_pkg::CAPACITY_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_func,
    input  wire logic signed [31:0] s_key_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic signed [31:0]      m_removed_key,
    output logic signed [31:0]      m_min_key,
    output logic signed [31:0]      m_max_key,
    output logic [10:0]             m_count
);
    localparam int AW = $clog2(CAPACITY + 1);
    localparam int PW = AW + 2;

    mmhq_pkg::mmhq_state_t state_reg, state_next;

    logic [AW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] p_reg, p_next;
    logic [PW-1:0] m_reg, m_next;
    logic [2:0]    j_reg, j_next;
    logic          wmax_reg, wmax_next;
    logic [1:0]    func_reg, func_next;
    logic signed [31:0] key_reg, key_next;
    logic signed [31:0] kb_reg, kb_next;
    logic signed [31:0] rem_reg, rem_next;
    logic [1:0]    stat_reg, stat_next;
    logic signed [31:0] k1_reg, k1_next, k2_reg, k2_next;
    logic          at3_reg, at3_next;
    logic signed [31:0] mn_reg, mn_next, mx_reg, mx_next;
    logic          mv_reg, mv_next;
    logic          rdpend_reg, rdpend_next;
    logic [PW-1:0] rdq_reg, rdq_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic signed [31:0] wdata, rdata;

    mmhq_ram #(.WIDTH(32), .DEPTH(CAPACITY + 1)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic [PW-1:0] q_j;
    logic          odd_lvl;
    logic [PW-1:0] cnt_ext;
    logic [AW-1:0] cnt_inc;

    assign cnt_ext = PW'(cnt_reg);
    assign cnt_inc = cnt_reg + AW'(1);

    always_comb begin
        case (j_reg)
            3'd0:    q_j = p_reg << 1;
            3'd1:    q_j = (p_reg << 1) + PW'(1);
            3'd2:    q_j = p_reg << 2;
            3'd3:    q_j = (p_reg << 2) + PW'(1);
            3'd4:    q_j = (p_reg << 2) + PW'(2);
            3'd5:    q_j = (p_reg << 2) + PW'(3);
            default: q_j = '1;
        endcase
    end

    always_comb begin
        odd_lvl = 1'b0;
        for (int b = 0; b < PW; b++) begin
            if (p_reg[b]) begin
                odd_lvl = b[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= mmhq_pkg::ST_IDLE;
            cnt_reg    <= '0;
            mv_reg     <= 1'b0;
            rdpend_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            mv_reg     <= mv_next;
            rdpend_reg <= rdpend_next;
        end
        p_reg    <= p_next;
        m_reg    <= m_next;
        j_reg    <= j_next;
        wmax_reg <= wmax_next;
        func_reg <= func_next;
        key_reg  <= key_next;
        kb_reg   <= kb_next;
        rem_reg  <= rem_next;
        stat_reg <= stat_next;
        k1_reg   <= k1_next;
        k2_reg   <= k2_next;
        at3_reg  <= at3_next;
        mn_reg   <= mn_next;
        mx_reg   <= mx_next;
        rdq_reg  <= rdq_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mmhq_pkg::ST_IDLE:
                if (s_valid && !mv_reg) state_next = mmhq_pkg::ST_DISPATCH;
            mmhq_pkg::ST_DISPATCH: begin
                if (func_reg == mmhq_pkg::FUNC_INSERT) begin
                    if (cnt_reg == AW'(CAPACITY)) state_next = mmhq_pkg::ST_PK_RD1;
                    else if (cnt_reg == '0) state_next = mmhq_pkg::ST_PLACE;
                    else state_next = mmhq_pkg::ST_INS_CMP_PAR;
                end else if (func_reg == mmhq_pkg::FUNC_POP_MIN ||
                             func_reg == mmhq_pkg::FUNC_POP_MAX) begin
                    if (cnt_reg == '0) state_next = mmhq_pkg::ST_PK_RD1;
                    else state_next = mmhq_pkg::ST_REM_LAST;
                end else begin
                    state_next = mmhq_pkg::ST_PK_RD1;
                end
            end
            mmhq_pkg::ST_INS_CMP_PAR:  state_next = mmhq_pkg::ST_BUB_RD;
            mmhq_pkg::ST_BUB_RD:
                state_next = ((p_reg >> 2) == '0) ? mmhq_pkg::ST_PLACE : mmhq_pkg::ST_BUB_CMP;
            mmhq_pkg::ST_BUB_CMP:
                state_next = mmhq_pkg::better(key_reg, rdata, wmax_reg) ?
                             mmhq_pkg::ST_BUB_RD : mmhq_pkg::ST_PLACE;
            mmhq_pkg::ST_REM_LAST:     state_next = mmhq_pkg::ST_TD_CHECK;
            mmhq_pkg::ST_TD_CHECK:
                state_next = ((p_reg << 1) <= cnt_ext) ? mmhq_pkg::ST_TD_RD : mmhq_pkg::ST_PLACE;
            mmhq_pkg::ST_TD_RD:
                if (!(q_j <= cnt_ext)) state_next = mmhq_pkg::ST_TD_SWAP;
            mmhq_pkg::ST_TD_SWAP: begin
                if (!mmhq_pkg::better(kb_reg, key_reg, wmax_reg)) state_next = mmhq_pkg::ST_PLACE;
                else if (m_reg <= (p_reg << 1) + PW'(1)) state_next = mmhq_pkg::ST_PLACE;
                else state_next = mmhq_pkg::ST_TD_CMP_PAR;
            end
            mmhq_pkg::ST_TD_CMP_PAR:   state_next = mmhq_pkg::ST_TD_CHECK;
            mmhq_pkg::ST_PLACE:        state_next = mmhq_pkg::ST_PK_RD1;
            mmhq_pkg::ST_PK_RD1:       state_next = mmhq_pkg::ST_PK_RD2;
            mmhq_pkg::ST_PK_RD2:       state_next = mmhq_pkg::ST_PK_RD3;
            mmhq_pkg::ST_PK_RD3:       state_next = mmhq_pkg::ST_PK_DONE;
            mmhq_pkg::ST_PK_DONE:      state_next = mmhq_pkg::ST_IDLE;
            default:                   state_next = mmhq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;   p_next = p_reg;     m_next = m_reg;
        j_next = j_reg;       wmax_next = wmax_reg; func_next = func_reg;
        key_next = key_reg;   kb_next = kb_reg;
        rem_next = rem_reg;   stat_next = stat_reg;
        k1_next = k1_reg;     k2_next = k2_reg;   at3_next = at3_reg;
        mn_next = mn_reg;     mx_next = mx_reg;   mv_next = mv_reg;
        rdpend_next = 1'b0;   rdq_next = rdq_reg;
        we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
        s_ready = 1'b0;
        if (mv_reg && m_ready) mv_next = 1'b0;
        unique case (state_reg)
            mmhq_pkg::ST_IDLE: begin
                s_ready = !mv_reg;
                if (s_valid && !mv_reg) begin
                    func_next = s_func;
                    key_next = s_key_in;
                    stat_next = mmhq_pkg::STATUS_OK;
                    rem_next = '0;
                end
            end
            mmhq_pkg::ST_DISPATCH: begin
                if (func_reg == mmhq_pkg::FUNC_INSERT) begin
                    if (cnt_reg == AW'(CAPACITY)) begin
                        stat_next = mmhq_pkg::STATUS_FULL;
                    end else begin
                        cnt_next = cnt_inc;
                        p_next = PW'(cnt_inc);
                        raddr = cnt_inc >> 1;
                    end
                end else if (func_reg == mmhq_pkg::FUNC_POP_MIN ||
                             func_reg == mmhq_pkg::FUNC_POP_MAX) begin
                    if (cnt_reg == '0) begin
                        stat_next = mmhq_pkg::STATUS_EMPTY;
                    end else begin
                        raddr = cnt_reg;
                        cnt_next = cnt_reg - AW'(1);
                        if (func_reg == mmhq_pkg::FUNC_POP_MIN || cnt_reg == AW'(1)) begin
                            p_next = PW'(1); wmax_next = 1'b0; rem_next = mn_reg;
                        end else if (cnt_reg == AW'(2)) begin
                            p_next = PW'(2); wmax_next = 1'b1; rem_next = mx_reg;
                        end else begin
                            p_next = at3_reg ? PW'(3) : PW'(2);
                            wmax_next = 1'b1; rem_next = mx_reg;
                        end
                    end
                end
            end
            mmhq_pkg::ST_INS_CMP_PAR: begin
                if (odd_lvl ? (key_reg < rdata) : (key_reg > rdata)) begin
                    we = 1'b1; waddr = AW'(p_reg); wdata = rdata;
                    p_next = p_reg >> 1;
                    wmax_next = !odd_lvl;
                end else begin
                    wmax_next = odd_lvl;
                end
            end
            mmhq_pkg::ST_BUB_RD: raddr = AW'(p_reg >> 2);
            mmhq_pkg::ST_BUB_CMP: begin
                if (mmhq_pkg::better(key_reg, rdata, wmax_reg)) begin
                    we = 1'b1; waddr = AW'(p_reg); wdata = rdata;
                    p_next = p_reg >> 2;
                end
            end
            mmhq_pkg::ST_REM_LAST: key_next = rdata;
            mmhq_pkg::ST_TD_CHECK: begin
                j_next = '0;
                m_next = '0;
            end
            mmhq_pkg::ST_TD_RD: begin
                if (rdpend_reg &&
                    (m_reg == '0 || mmhq_pkg::better(rdata, kb_reg, wmax_reg))) begin
                    m_next = rdq_reg; kb_next = rdata;
                end
                if (q_j <= cnt_ext) begin
                    raddr = AW'(q_j); rdq_next = q_j;
                    rdpend_next = 1'b1;
                    j_next = j_reg + 3'd1;
                end
            end
            mmhq_pkg::ST_TD_SWAP: begin
                raddr = AW'(m_reg >> 1);
                if (mmhq_pkg::better(kb_reg, key_reg, wmax_reg)) begin
                    we = 1'b1; waddr = AW'(p_reg); wdata = kb_reg;
                    p_next = m_reg;
                end
            end
            mmhq_pkg::ST_TD_CMP_PAR: begin
                if (mmhq_pkg::better(rdata, key_reg, wmax_reg)) begin
                    we = 1'b1; waddr = AW'(m_reg >> 1); wdata = key_reg;
                    key_next = rdata;
                end
            end
            mmhq_pkg::ST_PLACE: begin
                we = 1'b1; waddr = AW'(p_reg); wdata = key_reg;
            end
            mmhq_pkg::ST_PK_RD1: raddr = AW'(1);
            mmhq_pkg::ST_PK_RD2: begin
                raddr = AW'(2);
                k1_next = rdata;
            end
            mmhq_pkg::ST_PK_RD3: begin
                raddr = AW'(3);
                k2_next = rdata;
            end
            mmhq_pkg::ST_PK_DONE: begin
                mn_next = (cnt_reg == '0) ? 32'sd0 : k1_reg;
                if (cnt_reg == '0) mx_next = '0;
                else if (cnt_reg == AW'(1)) mx_next = k1_reg;
                else if (cnt_reg == AW'(2)) mx_next = k2_reg;
                else mx_next = (k2_reg > rdata) ? k2_reg : rdata;
                at3_next = !(k2_reg > rdata);
                mv_next = 1'b1;
            end
            default: ;
        endcase
    end

    assign m_valid       = mv_reg;
    assign m_status      = stat_reg;
    assign m_removed_key = rem_reg;
    assign m_min_key     = mn_reg;
    assign m_max_key     = mx_reg;
    assign m_count       = 11'(cnt_reg);
endmodule
`default_nettype wire

/* sv/mmhq_checker.sv */
`default_nettype none
module mmhq_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [1:0]         m_status,
    input wire logic signed [31:0] m_removed_key,
    input wire logic signed [31:0] m_min_key,
    input wire logic signed [31:0] m_max_key,
    input wire logic [10:0]        m_count
);
    a_not_both: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input ready while a result waits");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_count) && $stable(m_min_key))
        else $error("stalled result changed");
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_count != 11'd0 |-> m_min_key <= m_max_key)
        else $error("minimum above maximum");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_count == 11'd0 |-> m_min_key == 32'sd0 && m_max_key == 32'sd0)
        else $error("empty heap shows keys");
    a_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != mmhq_pkg::STATUS_OK |-> m_removed_key == 32'sd0)
        else $error("failed operation removed a key");
endmodule

bind min_max_heap_queue mmhq_checker u_mmhq_checker (.*);
`default_nettype wire
